### rtl/ssp_pkg.sv
package ssp_pkg;

    localparam int unsigned NUM_POS   = 7;
    localparam int unsigned BCD_W     = 4 * NUM_POS;
    localparam int unsigned BITS_PER_STAGE = 8;

    localparam logic [6:0]  MINUS_CODE = 7'h40;

    localparam logic [31:0] LIM_100     = 32'd100;
    localparam logic [31:0] LIM_1000    = 32'd1000;
    localparam logic [31:0] LIM_10000   = 32'd10000;
    localparam logic [31:0] LIM_100000  = 32'd100000;
    localparam logic [31:0] LIM_1000000 = 32'd1000000;

    // Pipeline stage contents; early stages leave bcd/ndig unused.
    typedef struct packed {
        logic              neg;
        logic              pt;
        logic [6:0]        leg_lo;
        logic [6:0]        leg_hi;
        logic [31:0]       mag;
        logic [BCD_W-1:0]  bcd;
        logic [2:0]        ndig;
        logic              lt100k;
    } stage_t;

    function automatic logic [6:0] seg_code(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

### rtl/ssp_in_if.sv
interface ssp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               point_on;
    logic [15:0]        legend_mask;

    modport source (output valid, value, point_on, legend_mask, input ready);
    modport sink   (input valid, value, point_on, legend_mask, output ready);
endinterface

### rtl/ssp_out_if.sv
interface ssp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  word0_low_bits;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] word3;

    modport source (output valid, word0_low_bits, word1, word2, word3, input ready);
    modport sink   (input valid, word0_low_bits, word1, word2, word3, output ready);
endinterface

### rtl/ssp_dabble.sv
module ssp_dabble (
    input  logic [ssp_pkg::BITS_PER_STAGE-1:0] bits,
    input  logic [ssp_pkg::BCD_W-1:0]          bcd_in,
    output logic [ssp_pkg::BCD_W-1:0]          bcd_out
);

    // Shift-and-add-3 over a slice of the magnitude, MSB first. Only the
    // lowest seven digits are kept; higher digits never feed lower ones.
    always_comb
    begin
        logic [ssp_pkg::BCD_W-1:0] acc;
        acc = bcd_in;
        for (int s = 0; s < int'(ssp_pkg::BITS_PER_STAGE); s++)
        begin
            for (int d = 0; d < int'(ssp_pkg::NUM_POS); d++)
            begin
                if (acc[4*d +: 4] >= 4'd5)
                begin
                    acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
                end
            end
            acc = {acc[ssp_pkg::BCD_W-2:0], bits[ssp_pkg::BITS_PER_STAGE-1-s]};
        end
        bcd_out = acc;
    end

endmodule

### rtl/signed_decimal_seven_segment_packer_top.sv
// Signed decimal seven-segment packer.
// Input channel (in_ch): value (signed 32 bits), point_on and legend_mask.
// Output channel (out_ch): the packed driver words word0_low_bits, word1,
// word2 and word3 for a seven-position display, one result per input.
// Both channels complete a transaction on a clock edge with valid and ready
// high.
// Throughput: one transaction per cycle while the receiver keeps ready
// high. The work runs through six register stages: magnitude, four
// binary-to-decimal stages of eight bits each, and the segment encode and
// pack stage.
// Each stage has its own valid bit and takes new data when it is empty or
// its successor moves, so bubbles are squeezed out and the block keeps
// taking input while a finished result waits, until every stage is full.
// A receiver stall holds the output register and its contents unchanged.
// Reset (rst_n low, asynchronous) empties the pipeline; no result is lost
// or repeated across a stall.
module signed_decimal_seven_segment_packer_top (
    input  logic          clk,
    input  logic          rst_n,
    ssp_in_if.sink        in_ch,
    ssp_out_if.source     out_ch
);

    localparam int unsigned NSTG = 5;

    ssp_pkg::stage_t st_reg  [NSTG];
    ssp_pkg::stage_t st_next [NSTG];
    logic [NSTG:0]   v_reg;
    logic [NSTG+1:0] rdy;

    logic [1:0]  w0_reg;
    logic [15:0] w1_reg;
    logic [15:0] w2_reg;
    logic [15:0] w3_reg;
    logic [1:0]  w0_next;
    logic [15:0] w1_next;
    logic [15:0] w2_next;
    logic [15:0] w3_next;

    logic [ssp_pkg::BCD_W-1:0] bcd_step [NSTG-1];

    // Stage k may load when it is empty or its contents move on.
    always_comb
    begin
        rdy[NSTG+1] = out_ch.ready;
        for (int k = NSTG; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ch.ready = rdy[0];

    genvar g;
    generate
        for (g = 1; g < int'(NSTG); g++)
        begin : g_dabble
            ssp_dabble u_dabble (
                .bits    (st_reg[g-1].mag[32-ssp_pkg::BITS_PER_STAGE*g +:
                                          ssp_pkg::BITS_PER_STAGE]),
                .bcd_in  (st_reg[g-1].bcd),
                .bcd_out (bcd_step[g-1])
            );
        end
    endgenerate

    always_comb
    begin
        logic [31:0] raw;
        logic [31:0] m;
        raw = in_ch.value;
        st_next[0]        = '0;
        st_next[0].neg    = raw[31];
        st_next[0].pt     = in_ch.point_on;
        st_next[0].leg_lo = in_ch.legend_mask[6:0];
        st_next[0].leg_hi = in_ch.legend_mask[14:8];
        st_next[0].mag    = raw[31] ? (~raw + 32'd1) : raw;

        for (int k = 1; k < int'(NSTG); k++)
        begin
            st_next[k]     = st_reg[k-1];
            st_next[k].bcd = bcd_step[k-1];
        end

        // Digit count and legend condition come from the first decimal stage.
        m = st_reg[0].mag;
        if (m >= ssp_pkg::LIM_1000000)
        begin
            st_next[1].ndig = 3'd7;
        end
        else if (m >= ssp_pkg::LIM_100000)
        begin
            st_next[1].ndig = 3'd6;
        end
        else if (m >= ssp_pkg::LIM_10000)
        begin
            st_next[1].ndig = 3'd5;
        end
        else if (m >= ssp_pkg::LIM_1000)
        begin
            st_next[1].ndig = 3'd4;
        end
        else if (m >= ssp_pkg::LIM_100)
        begin
            st_next[1].ndig = 3'd3;
        end
        else
        begin
            st_next[1].ndig = 3'd2;
        end
        st_next[1].lt100k = (m < ssp_pkg::LIM_100000);
    end

    // Segment encode and packing.
    always_comb
    begin
        logic [6:0]      p [ssp_pkg::NUM_POS];
        ssp_pkg::stage_t s;
        s = st_reg[NSTG-1];
        for (int i = 0; i < int'(ssp_pkg::NUM_POS); i++)
        begin
            if (3'(i) < s.ndig)
            begin
                p[i] = ssp_pkg::seg_code(s.bcd[4*i +: 4]);
            end
            else if (3'(i) == s.ndig && s.neg)
            begin
                p[i] = ssp_pkg::MINUS_CODE;
            end
            else
            begin
                p[i] = 7'h00;
            end
        end
        if (s.lt100k)
        begin
            p[5] = s.leg_lo;
            p[6] = s.leg_hi;
        end
        w0_next = p[0][6:5];
        w1_next = {p[0][4:0], s.pt, p[1], p[2][6:4]};
        w2_next = {p[2][3:0], p[3], p[4][6:2]};
        w3_next = {p[4][1:0], p[5], p[6]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_ch.valid;
            end
            for (int k = 1; k <= int'(NSTG); k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < int'(NSTG); k++)
        begin
            if (rdy[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
        if (rdy[NSTG])
        begin
            w0_reg <= w0_next;
            w1_reg <= w1_next;
            w2_reg <= w2_next;
            w3_reg <= w3_next;
        end
    end

    assign out_ch.valid          = v_reg[NSTG];
    assign out_ch.word0_low_bits = w0_reg;
    assign out_ch.word1          = w1_reg;
    assign out_ch.word2          = w2_reg;
    assign out_ch.word3          = w3_reg;

endmodule

### tb/segment_word_checker.sv
`timescale 1ns / 1ps

module segment_word_checker (
    input  logic        clk,
    input  logic        rst_n,
    ssp_in_if           in_ch,
    ssp_out_if          out_ch,
    output int unsigned errors,
    output int unsigned pending,
    output int unsigned checked
);

    typedef struct packed {
        logic [1:0]  word0_low_bits;
        logic [15:0] word1;
        logic [15:0] word2;
        logic [15:0] word3;
    } drive_words_t;

    localparam logic [6:0] DASH_SEG = 7'h40;

    // Segment patterns for digits 9 down to 0, seven bits each.
    localparam logic [69:0] DIGIT_SEGS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                          7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

    drive_words_t expected_words [$];
    drive_words_t got;
    drive_words_t want;
    int unsigned  err_count = 0;
    int unsigned  match_count = 0;
    int unsigned  queued = 0;

    assign errors  = err_count;
    assign pending = queued;
    assign checked = match_count;

    function automatic drive_words_t predict_words(input logic [31:0] value,
                                                   input logic point_on,
                                                   input logic [15:0] legend_mask);
        logic         neg;
        logic [31:0]  mag;
        logic [31:0]  rest;
        int           ndig;
        logic [6:0]   pos [7];
        drive_words_t w;
        neg = value[31];
        // The most negative value wraps to itself and reads as unsigned.
        mag = neg ? (32'd0 - value) : value;
        if (mag >= 32'd1000000)     ndig = 7;
        else if (mag >= 32'd100000) ndig = 6;
        else if (mag >= 32'd10000)  ndig = 5;
        else if (mag >= 32'd1000)   ndig = 4;
        else if (mag >= 32'd100)    ndig = 3;
        else                        ndig = 2;
        rest = mag;
        for (int i = 0; i < 7; i++)
        begin
            if (i < ndig)
            begin
                pos[i] = DIGIT_SEGS[(rest % 10) * 7 +: 7];
                rest   = rest / 10;
            end
            else if (i == ndig && neg)
                pos[i] = DASH_SEG;
            else
                pos[i] = 7'd0;
        end
        if (mag < 32'd100000)
        begin
            pos[5] = legend_mask[6:0];
            pos[6] = legend_mask[14:8];
        end
        w.word0_low_bits = pos[0][6:5];
        w.word1 = {pos[0][4:0], point_on, pos[1], pos[2][6:4]};
        w.word2 = {pos[2][3:0], pos[3], pos[4][6:2]};
        w.word3 = {pos[4][1:0], pos[5], pos[6]};
        return w;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // A result cannot leave in the same cycle as its input, so the
            // output side is handled before this cycle's input is queued.
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.word0_low_bits, out_ch.word1, out_ch.word2, out_ch.word3};
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result transaction: word1 %h word2 %h word3 %h",
                           got.word1, got.word2, got.word3);
                    err_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.word0_low_bits !== want.word0_low_bits)
                    begin
                        $error("word0_low_bits mismatch: expected %h, actual %h",
                               want.word0_low_bits, got.word0_low_bits);
                        err_count++;
                    end
                    if (got.word1 !== want.word1)
                    begin
                        $error("word1 mismatch: expected %h, actual %h", want.word1, got.word1);
                        err_count++;
                    end
                    if (got.word2 !== want.word2)
                    begin
                        $error("word2 mismatch: expected %h, actual %h", want.word2, got.word2);
                        err_count++;
                    end
                    if (got.word3 !== want.word3)
                    begin
                        $error("word3 mismatch: expected %h, actual %h", want.word3, got.word3);
                        err_count++;
                    end
                    match_count++;
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_words.push_back(predict_words(in_ch.value, in_ch.point_on,
                                                       in_ch.legend_mask));
            queued = expected_words.size();
        end
    end

endmodule

### tb/tb_signed_decimal_seven_segment_packer_top.sv
`timescale 1ns / 1ps

module tb_signed_decimal_seven_segment_packer_top;

    localparam int RANDOM_ITEMS = 1625;
    localparam int DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        calm;
    int unsigned errors;
    int unsigned pending;
    int unsigned checked;
    int unsigned n_sent;

    ssp_in_if  in_ch ();
    ssp_out_if out_ch ();

    signed_decimal_seven_segment_packer_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    segment_word_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Receiver: mostly ready, with short and occasionally long stalls.
    initial
    begin
        int unsigned r;
        int unsigned len;
        logic        lvl;
        out_ch.ready = 1'b0;
        forever
        begin
            r = $urandom_range(0, 99);
            if (calm)
            begin
                lvl = 1'b1;
                len = 1;
            end
            else if (r < 70)
            begin
                lvl = 1'b1;
                len = $urandom_range(1, 6);
            end
            else
            begin
                lvl = 1'b0;
                len = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            end
            repeat (len)
            begin
                @(negedge clk);
                out_ch.ready <= lvl;
            end
        end
    end

    task automatic send_item(input logic signed [31:0] v, input logic p,
                             input logic [15:0] m);
        int unsigned gap;
        gap = pick_gap();
        // Junk payload while idle must be ignored by the block.
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid       <= 1'b0;
            in_ch.value       <= $urandom();
            in_ch.point_on    <= 1'($urandom_range(0, 1));
            in_ch.legend_mask <= 16'($urandom());
        end
        @(negedge clk);
        in_ch.valid       <= 1'b1;
        in_ch.value       <= v;
        in_ch.point_on    <= p;
        in_ch.legend_mask <= m;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic wait_until_empty();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [31:0] random_value();
        logic [31:0] mag;
        int unsigned cls;
        int unsigned k;
        cls = $urandom_range(0, 9);
        case (cls)
            0: mag = $urandom_range(0, 99);
            1: mag = $urandom_range(100, 999);
            2: mag = $urandom_range(1000, 9999);
            3: mag = $urandom_range(10000, 99999);
            4: mag = $urandom_range(100000, 999999);
            5: mag = $urandom_range(1000000, 9999999);
            6:
            begin
                // Either side of a digit-count boundary.
                k   = $urandom_range(2, 7);
                mag = 1;
                repeat (k) mag = mag * 10;
                mag = mag - $urandom_range(0, 1);
            end
            default: return $urandom();
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    initial
    begin
        n_sent            = 0;
        calm              = 1'b0;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.value       = '0;
        in_ch.point_on    = 1'b0;
        in_ch.legend_mask = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Digit-count edges, sign placement, sign hidden by the legend,
        // sign dropped at seven digits, truncation and the most negative value.
        send_item(0,            1'b1, 16'hFFFF);
        send_item(1,            1'b0, 16'h0000);
        send_item(-1,           1'b1, 16'h8080);
        send_item(-9,           1'b0, 16'h7F7F);
        send_item(99,           1'b1, 16'h1234);
        send_item(-99,          1'b0, 16'hFFFF);
        send_item(100,          1'b1, 16'h0000);
        send_item(-999,         1'b0, 16'h5A3C);
        send_item(1000,         1'b1, 16'h8080);
        send_item(-9999,        1'b0, 16'h7F7F);
        send_item(10000,        1'b1, 16'hFFFF);
        send_item(-12345,       1'b0, 16'h0000);
        send_item(99999,        1'b1, 16'hA5C3);
        send_item(-99999,       1'b1, 16'h0000);
        send_item(100000,       1'b0, 16'hFFFF);
        send_item(-100000,      1'b1, 16'hFFFF);
        send_item(999999,       1'b0, 16'h7F7F);
        send_item(-999999,      1'b1, 16'h0000);
        send_item(1000000,      1'b0, 16'hFFFF);
        send_item(-1000000,     1'b1, 16'hFFFF);
        send_item(9999999,      1'b0, 16'h0000);
        send_item(10000000,     1'b1, 16'h8080);
        send_item(2147483647,   1'b0, 16'hFFFF);
        send_item(-2147483647,  1'b1, 16'h0000);
        send_item(32'h80000000, 1'b1, 16'hFFFF);
        wait_until_empty();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i > 0 && i % 500 == 0)
                wait_until_empty();
            send_item(random_value(), 1'($urandom_range(0, 1)), 16'($urandom()));
        end
        calm = 1'b0;
        wait_until_empty();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d inputs over every digit count, both signs, legend overlap,",
                 n_sent);
        $display("dropped sign and truncation, with random gaps and stalls; %0d results compared.",
                 checked);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
